>>> src/qm_pkg.sv
`default_nettype none
package qm_pkg;

	localparam int FRAC_BITS = 14;
	localparam int DATA_W = 16;
	localparam int THR_W = 15;
	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W = PROD_W + 2;

	typedef logic signed [DATA_W-1:0] comp_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef enum logic [1:0] {
		SRC_PRODUCT = 2'd0,
		SRC_SECOND  = 2'd1,
		SRC_FIRST   = 2'd2,
		SRC_BOTH    = 2'd3
	} source_t;

endpackage
`default_nettype wire

>>> src/qm_round_sat.sv
`default_nettype none
module qm_round_sat
	import qm_pkg::*;
(
	input  sum_t  sum,
	output comp_t value,
	output logic  clip
);

	localparam sum_t HALF = sum_t'(1) <<< (FRAC_BITS - 1);
	localparam sum_t RES_MAX = sum_t'(32767);
	localparam sum_t RES_MIN = -sum_t'(32768);

	sum_t shifted;

	always_comb begin
		shifted = (sum + HALF) >>> FRAC_BITS;
		if (shifted > RES_MAX) begin
			value = comp_t'(RES_MAX);
			clip = 1'b1;
		end else if (shifted < RES_MIN) begin
			value = comp_t'(RES_MIN);
			clip = 1'b1;
		end else begin
			value = shifted[DATA_W-1:0];
			clip = 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> src/quaternion_multiply_top.sv
`default_nettype none
// Hamilton product of two Q2.14 quaternions in a four-stage pipeline: input and bypass
// decision, sixteen 16x16 products, four sums of four products, then rounding, saturation
// and result selection into the output register. A word is accepted every cycle while in_stall
// is low, and its result moves on from the input register through the product, sum and output
// registers in turn. Stages that hold no word keep accepting while
// a finished result waits under stall. A scalar part whose magnitude is below
// zero_threshold makes the other quaternion pass through unchanged, and when both scalars
// are below it the result is zero with result_source set to three.
module quaternion_multiply_top
	import qm_pkg::*;
(
	input  wire  logic              clk,
	input  wire  logic              arst_n,
	input  wire  logic              cfg_we,
	input  wire  logic [THR_W-1:0]  cfg_wdata,
	input  wire  logic              in_valid,
	output logic                    in_stall,
	input  wire  comp_t             first_w,
	input  wire  comp_t             first_x,
	input  wire  comp_t             first_y,
	input  wire  comp_t             first_z,
	input  wire  comp_t             second_w,
	input  wire  comp_t             second_x,
	input  wire  comp_t             second_y,
	input  wire  comp_t             second_z,
	output logic                    out_valid,
	input  wire  logic              out_stall,
	output comp_t                   result_w,
	output comp_t                   result_x,
	output comp_t                   result_y,
	output comp_t                   result_z,
	output logic [1:0]              result_source,
	output logic                    saturated
);

	logic [THR_W-1:0] zero_threshold_q;

	comp_t in_a [4];
	comp_t in_b [4];
	logic [DATA_W:0] mag_a;
	logic [DATA_W:0] mag_b;
	logic near_a;
	logic near_b;
	source_t in_src;
	comp_t in_byp [4];

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	comp_t a_s1 [4];
	comp_t b_s1 [4];
	comp_t byp_s1 [4];
	source_t src_s1;

	prod_t prod_s2 [4][4];
	comp_t byp_s2 [4];
	source_t src_s2;

	sum_t sum_s3 [4];
	comp_t byp_s3 [4];
	source_t src_s3;

	comp_t res_s4 [4];
	source_t src_s4;
	logic sat_s4;

	comp_t rnd [4];
	logic [3:0] clip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_threshold_q <= THR_W'(16);
		end else if (cfg_we) begin
			zero_threshold_q <= cfg_wdata;
		end
	end

	assign in_a[0] = first_w;
	assign in_a[1] = first_x;
	assign in_a[2] = first_y;
	assign in_a[3] = first_z;
	assign in_b[0] = second_w;
	assign in_b[1] = second_x;
	assign in_b[2] = second_y;
	assign in_b[3] = second_z;

	always_comb begin
		mag_a = first_w[DATA_W-1] ? -{first_w[DATA_W-1], first_w} : {first_w[DATA_W-1], first_w};
		mag_b = second_w[DATA_W-1] ? -{second_w[DATA_W-1], second_w}
			: {second_w[DATA_W-1], second_w};
		near_a = mag_a < {2'b00, zero_threshold_q};
		near_b = mag_b < {2'b00, zero_threshold_q};
		priority if (near_a && near_b) begin
			in_src = SRC_BOTH;
		end else if (near_a) begin
			in_src = SRC_SECOND;
		end else if (near_b) begin
			in_src = SRC_FIRST;
		end else begin
			in_src = SRC_PRODUCT;
		end
		for (int i = 0; i < 4; i++) begin
			unique case (in_src)
				SRC_SECOND: in_byp[i] = in_b[i];
				SRC_FIRST:  in_byp[i] = in_a[i];
				default:    in_byp[i] = '0;
			endcase
		end
	end

	assign adv4 = !v_s4 || !out_stall;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			a_s1 <= in_a;
			b_s1 <= in_b;
			byp_s1 <= in_byp;
			src_s1 <= in_src;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s2[i][j] <= a_s1[i] * b_s1[j];
				end
			end
			byp_s2 <= byp_s1;
			src_s2 <= src_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			sum_s3[0] <= sum_t'(prod_s2[0][0]) - sum_t'(prod_s2[1][1])
				- sum_t'(prod_s2[2][2]) - sum_t'(prod_s2[3][3]);
			sum_s3[1] <= sum_t'(prod_s2[0][1]) + sum_t'(prod_s2[1][0])
				+ sum_t'(prod_s2[2][3]) - sum_t'(prod_s2[3][2]);
			sum_s3[2] <= sum_t'(prod_s2[0][2]) + sum_t'(prod_s2[2][0])
				+ sum_t'(prod_s2[3][1]) - sum_t'(prod_s2[1][3]);
			sum_s3[3] <= sum_t'(prod_s2[0][3]) + sum_t'(prod_s2[3][0])
				+ sum_t'(prod_s2[1][2]) - sum_t'(prod_s2[2][1]);
			byp_s3 <= byp_s2;
			src_s3 <= src_s2;
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_round
		qm_round_sat u_round (
			.sum   (sum_s3[g]),
			.value (rnd[g]),
			.clip  (clip[g])
		);
	end

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			if (src_s3 == SRC_PRODUCT) begin
				res_s4 <= rnd;
				sat_s4 <= |clip;
			end else begin
				res_s4 <= byp_s3;
				sat_s4 <= 1'b0;
			end
			src_s4 <= src_s3;
		end
	end

	assign out_valid = v_s4;
	assign result_w = res_s4[0];
	assign result_x = res_s4[1];
	assign result_y = res_s4[2];
	assign result_z = res_s4[3];
	assign result_source = src_s4;
	assign saturated = sat_s4;

endmodule
`default_nettype wire

>>> src/qm_checker.sv
`default_nettype none
module qm_checker
	import qm_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire comp_t      result_w,
	input wire comp_t      result_x,
	input wire comp_t      result_y,
	input wire comp_t      result_z,
	input wire logic [1:0] result_source,
	input wire logic       saturated
);

	localparam comp_t C_MAX = comp_t'(32767);
	localparam comp_t C_MIN = comp_t'(-32768);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
	else $error("result word dropped under stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result_w) && $stable(result_source))
	else $error("stalled result word changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_source == SRC_BOTH |->
			result_w == 0 && result_x == 0 && result_y == 0 && result_z == 0)
	else $error("both-near-zero result is not zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_source != SRC_PRODUCT |-> !saturated)
	else $error("saturation flagged on a passed-through word");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			result_w == C_MAX || result_w == C_MIN || result_x == C_MAX || result_x == C_MIN
			|| result_y == C_MAX || result_y == C_MIN || result_z == C_MAX
			|| result_z == C_MIN)
	else $error("saturation flagged without a clipped component");

endmodule

bind quaternion_multiply_top qm_checker u_qm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.result_w      (result_w),
	.result_x      (result_x),
	.result_y      (result_y),
	.result_z      (result_z),
	.result_source (result_source),
	.saturated     (saturated)
);
`default_nettype wire
